// File: rtl/purl_pkg.sv
// Shared constants, types and register codes for the per-user rate limiter.
// No dependencies; the divider and the core refer to it by scoped names.
package purl_pkg;

	localparam int USER_SLOTS = 64;
	localparam int SLOT_W     = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
	localparam int IDX_EXT_W  = 11;   // holds any slot count up to 1024

	localparam int IDX_W   = 6;
	localparam int TS_W    = 32;
	localparam int CNT_W   = 8;
	localparam int WIN_W   = 16;
	localparam int PROD_W  = CNT_W + WIN_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int S_DATA_W = 40;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 16;

	// divider retires two quotient bits per cycle
	localparam int DIV_CYCLES = CNT_W / 2;
	localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	localparam logic [CFG_IDX_W-1:0] REG_FREE_MAX     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREE_WINDOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PREMIUM_MAX  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREMIUM_WIN  = 2'd3;

	localparam logic MODE_TOKEN  = 1'b0;
	localparam logic MODE_WINDOW = 1'b1;

	typedef struct packed {
		logic             mode;
		logic             tier;
		logic [CNT_W-1:0] count;
		logic [TS_W-1:0]  ts;     // refill time or window start
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/purl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module purl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/purl_div.sv
// Radix-4 restoring divider for the token refill (product / window).
// Depends on purl_pkg; quotient is known to fit in CNT_W bits.
module purl_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [purl_pkg::PROD_W-1:0]  dividend,
	input  logic [purl_pkg::WIN_W-1:0]   divisor,
	output logic                         done,
	output logic [purl_pkg::CNT_W-1:0]   quotient
);

	localparam int WW = purl_pkg::WIN_W;
	localparam int CW = purl_pkg::CNT_W;

	logic [WW-1:0]                  rem_q;
	logic [WW-1:0]                  dvs_q;
	logic [CW-1:0]                  quo_q;
	logic [purl_pkg::DIV_CNT_W-1:0] step_q;
	logic                           busy_q;

	logic [WW:0]   t1, t2;
	logic          ge1, ge2;
	logic [WW-1:0] r1, r2;

	// partial remainder stays below the divisor, so WW bits suffice
	always_comb begin
		t1  = {rem_q, quo_q[CW-1]};
		ge1 = t1 >= {1'b0, dvs_q};
		r1  = ge1 ? WW'(t1 - {1'b0, dvs_q}) : t1[WW-1:0];
		t2  = {r1, quo_q[CW-2]};
		ge2 = t2 >= {1'b0, dvs_q};
		r2  = ge2 ? WW'(t2 - {1'b0, dvs_q}) : t2[WW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[purl_pkg::PROD_W-1:CW];
			quo_q <= dividend[CW-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= r2;
			quo_q <= {quo_q[CW-3:0], ge1, ge2};
		end
	end

	assign done     = busy_q && (step_q == purl_pkg::DIV_CNT_W'(purl_pkg::DIV_CYCLES - 1));
	assign quotient = quo_q;

endmodule

// File: rtl/per_user_rate_limiter_core.sv
// Per-user rate limiter top level: handshakes, config registers, sequencer.
// Depends on purl_pkg, purl_ram (entry store) and purl_div (refill divider).

// Polices one request beat at a time, with state kept per user slot, in
// token-bucket or fixed-window mode fixed when the slot's entry is created.
// A beat goes from accept to the next ready through accept, entry read, update
// and write back; a token-mode beat that refills also passes through the
// multiply stage and the 2-bit-per-cycle divider. The result beat sits in an
// output register, so the next request is taken while it waits; the sequencer
// holds in its final state only if the previous result has not left yet.
// Entry valid bits all clear at reset; there is no clearing pass.
// Config writes are meant for idle periods only.
module per_user_rate_limiter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [purl_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [purl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [purl_pkg::S_DATA_W-1:0]   s_tdata,  // user_index[5:0], timestamp[37:6]
	input  logic [purl_pkg::S_USER_W-1:0]   s_tuser,  // user_tier[0], limiter_mode[1]
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [purl_pkg::M_DATA_W-1:0]   m_tdata   // allowed[0], created[1],
	                                                  // window_restarted[2], count_after[10:3]
);

	localparam int CW = purl_pkg::CNT_W;
	localparam int WW = purl_pkg::WIN_W;
	localparam int TW = purl_pkg::TS_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// ---- config registers ----
	logic [CW-1:0] free_max_q, prem_max_q;
	logic [WW-1:0] free_win_q, prem_win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_max_q <= CW'(3);
			free_win_q <= WW'(5);
			prem_max_q <= CW'(5);
			prem_win_q <= WW'(5);
		end else if (cfg_we) begin
			case (cfg_addr)
				purl_pkg::REG_FREE_MAX:    free_max_q <= cfg_wdata[CW-1:0];
				purl_pkg::REG_FREE_WINDOW: free_win_q <= cfg_wdata[WW-1:0];
				purl_pkg::REG_PREMIUM_MAX: prem_max_q <= cfg_wdata[CW-1:0];
				purl_pkg::REG_PREMIUM_WIN: prem_win_q <= cfg_wdata[WW-1:0];
				default: ;
			endcase
		end
	end

	// ---- request unpack ----
	logic                              in_fire;
	logic [purl_pkg::IDX_W-1:0]        in_idx;
	logic [TW-1:0]                     in_ts;
	logic [purl_pkg::IDX_EXT_W-1:0]    in_idx_ext;
	logic [purl_pkg::SLOT_W-1:0]       in_slot;
	logic                              in_oor;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_fire    = s_tvalid && s_tready;
	assign in_idx     = s_tdata[purl_pkg::IDX_W-1:0];
	assign in_ts      = s_tdata[purl_pkg::IDX_W +: TW];
	assign in_idx_ext = purl_pkg::IDX_EXT_W'(in_idx);
	assign in_slot    = in_idx_ext[purl_pkg::SLOT_W-1:0];
	// slot beyond the table: blocked, no state change, all-zero result
	assign in_oor     = in_idx_ext >= purl_pkg::IDX_EXT_W'(purl_pkg::USER_SLOTS);

	logic [purl_pkg::SLOT_W-1:0] slot_q;
	logic                        oor_q, req_tier_q, req_mode_q;
	logic [TW-1:0]               req_ts_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q     <= in_slot;
			oor_q      <= in_oor;
			req_tier_q <= s_tuser[0];
			req_mode_q <= s_tuser[1];
			req_ts_q   <= in_ts;
		end
	end

	// ---- entry store ----
	logic [purl_pkg::USER_SLOTS-1:0] valid_q;
	logic                            ram_we;
	logic [purl_pkg::ENTRY_W-1:0]    ram_rdata;
	purl_pkg::entry_t                ent_new;

	purl_ram #(
		.WIDTH(purl_pkg::ENTRY_W),
		.DEPTH(purl_pkg::USER_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(ent_new),
		.re   (in_fire),
		.raddr(in_slot),
		.rdata(ram_rdata)
	);

	// ---- EVAL: merge stored entry or create a new one ----
	purl_pkg::entry_t rd_ent, ent_e;
	logic             hit, tier_e;
	logic [CW-1:0]    maxr_e;
	logic [WW-1:0]    win_e, w_e;
	logic [TW-1:0]    el_e;
	logic [WW-1:0]    elc_e;
	logic             refill_e;

	always_comb begin
		rd_ent = purl_pkg::entry_t'(ram_rdata);
		hit    = valid_q[slot_q];
		tier_e = hit ? rd_ent.tier : req_tier_q;
		maxr_e = tier_e ? prem_max_q : free_max_q;
		win_e  = tier_e ? prem_win_q : free_win_q;
		if (hit) begin
			ent_e = rd_ent;
		end else begin
			ent_e.mode  = req_mode_q;
			ent_e.tier  = req_tier_q;
			ent_e.count = (req_mode_q == purl_pkg::MODE_TOKEN) ? maxr_e : '0;
			ent_e.ts    = req_ts_q;
		end
		// zero window refills as if it were one timestamp unit
		w_e      = (win_e == '0) ? WW'(1) : win_e;
		el_e     = req_ts_q - ent_e.ts;
		elc_e    = (el_e > TW'(w_e)) ? w_e : el_e[WW-1:0];
		refill_e = (ent_e.mode == purl_pkg::MODE_TOKEN) && (req_ts_q > ent_e.ts) && !oor_q;
	end

	purl_pkg::entry_t ent_q;
	logic             created_q, refill_q;
	logic [WW-1:0]    el_q, w_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			ent_q     <= ent_e;
			created_q <= !hit;
			refill_q  <= refill_e;
			el_q      <= elc_e;
			w_q       <= w_e;
		end
	end

	// ---- MUL / DIV: refill = elapsed * max / window ----
	logic [CW-1:0]              maxr_d;
	logic [WW-1:0]              win_d;
	logic [purl_pkg::PROD_W-1:0] prod;
	logic                       div_start, div_done;
	logic [CW-1:0]              quo;

	assign maxr_d    = ent_q.tier ? prem_max_q : free_max_q;
	assign win_d     = ent_q.tier ? prem_win_q : free_win_q;
	assign prod      = purl_pkg::PROD_W'(el_q) * purl_pkg::PROD_W'(maxr_d);
	assign div_start = (state_q == ST_MUL);

	// divider registers the product on start
	purl_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod),
		.divisor (w_q),
		.done    (div_done),
		.quotient(quo)
	);

	// ---- DONE: final update ----
	logic [CW:0]   sum;
	logic [CW-1:0] tok_cnt;
	logic [TW:0]   win_end;
	logic          restart;
	logic          allowed, restarted;
	logic          out_free, finish;

	always_comb begin
		ent_new   = ent_q;
		allowed   = 1'b0;
		restarted = 1'b0;
		sum       = {1'b0, ent_q.count} + {1'b0, quo};
		win_end   = {1'b0, ent_q.ts} + (TW + 1)'(win_d);
		restart   = created_q || ({1'b0, req_ts_q} > win_end);
		tok_cnt   = ent_q.count;
		if (ent_q.mode == purl_pkg::MODE_TOKEN) begin
			if (refill_q) begin
				tok_cnt    = (sum > {1'b0, maxr_d}) ? maxr_d : sum[CW-1:0];
				ent_new.ts = req_ts_q;
			end
			ent_new.count = tok_cnt;
			if (tok_cnt != '0) begin
				ent_new.count = tok_cnt - 1'b1;
				allowed       = 1'b1;
			end
		end else begin
			if (restart) begin
				ent_new.ts    = req_ts_q;
				ent_new.count = '0;
				restarted     = 1'b1;
			end
			// compare in 8 bits: a count at 255 is never below max
			if (ent_new.count < maxr_d) begin
				ent_new.count = ent_new.count + 1'b1;
				allowed       = 1'b1;
			end
		end
	end

	assign out_free = !m_tvalid || m_tready;
	assign finish   = (state_q == ST_DONE) && out_free;
	assign ram_we   = finish && !oor_q;

	// ---- sequencer ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire)  state_d = ST_EVAL;
			ST_EVAL: state_d = refill_e ? ST_MUL : ST_DONE;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				valid_q[slot_q] <= 1'b1;
			end
		end
	end

	// ---- result register ----
	logic                         m_valid_q;
	logic [purl_pkg::M_DATA_W-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (oor_q) begin
				m_data_q <= '0;
			end else begin
				m_data_q <= purl_pkg::M_DATA_W'({ent_new.count, restarted, created_q, allowed});
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_EVAL))
		else $error("accepted beat did not move to entry evaluation");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	a_write_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_DONE) && !oor_q && out_free))
		else $error("entry write outside the final state");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(slot_q)])
		else $error("written entry not marked valid");
`endif

endmodule
